// ===== hw/rtl/kmse_pkg.sv =====
// Types, constants and key map tables shared by the key matrix scan encoder.
// No dependencies.
`default_nettype none

package kmse_pkg;

   localparam int unsigned ColWidth      = 14;
   localparam int unsigned RowWidth      = 8;
   localparam int unsigned TickWidth     = 16;
   localparam int unsigned CodeWidth     = 8;
   localparam int unsigned ColIdxWidth   = 4;

   localparam logic [TickWidth-1:0]   DEBOUNCE_RESET = 16'd50;
   localparam logic [CodeWidth-1:0]   LOWER_FLOOR    = 8'd96;
   localparam logic [CodeWidth-1:0]   LOWER_CEIL     = 8'd123;
   localparam logic [CodeWidth-1:0]   CASE_OFFSET    = 8'd32;
   localparam logic [ColIdxWidth-1:0] G1_LAST_COL    = 4'd9;
   localparam logic [ColIdxWidth-1:0] G2_FIRST_COL   = 4'd10;
   localparam logic [ColIdxWidth-1:0] G2_LAST_COL    = 4'd13;
   localparam logic [ColIdxWidth-1:0] CAPS_COL       = 4'd2;
   localparam logic [3:0]             CAPS_ROW       = 4'd2;

   localparam logic [1:0] PHASE_G1_COLS = 2'd0;
   localparam logic [1:0] PHASE_G1_ROWS = 2'd1;
   localparam logic [1:0] PHASE_G2_COLS = 2'd2;
   localparam logic [1:0] PHASE_G2_ROWS = 2'd3;

   localparam logic [CodeWidth-1:0] MAP_G1 [3][10] = '{
      '{8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69, 8'h6f, 8'h70},
      '{8'h20, 8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c},
      '{8'h0a, 8'h01, 8'h02, 8'h7a, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6e, 8'h6d}
   };

   localparam logic [CodeWidth-1:0] MAP_G2 [5][4] = '{
      '{8'h37, 8'h38, 8'h39, 8'h2d},
      '{8'h34, 8'h35, 8'h36, 8'h2b},
      '{8'h31, 8'h32, 8'h33, 8'h2f},
      '{8'h30, 8'h2e, 8'h03, 8'h2a},
      '{8'h04, 8'h06, 8'h05, 8'h07}
   };

   typedef enum logic [7:0] {
      G1_COL  = 8'b0000_0001,
      G1_WAIT = 8'b0000_0010,
      G1_ROW  = 8'b0000_0100,
      G1_HOLD = 8'b0000_1000,
      G2_COL  = 8'b0001_0000,
      G2_WAIT = 8'b0010_0000,
      G2_ROW  = 8'b0100_0000,
      G2_HOLD = 8'b1000_0000
   } scan_state_type;

   typedef struct packed {
      scan_state_type           scan;
      logic [TickWidth-1:0]     wait_count;
      logic [ColIdxWidth-1:0]   held_column;
      logic                     caps_flag;
   } scan_ctx_type;

   typedef struct packed {
      logic [ColWidth-1:0] col_sense;
      logic [RowWidth-1:0] row_sense;
   } req_type;

   typedef struct packed {
      logic [1:0]           drive_phase;
      logic                 key_valid;
      logic [CodeWidth-1:0] key_code;
      logic                 key_held;
      logic                 caps_on;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hw/rtl/kmse_step.sv =====
// Scan step logic: column/row priority encoders, key map lookup and caps handling.
// Depends on kmse_pkg.
`default_nettype none

module kmse_step (
   input  kmse_pkg::scan_ctx_type          ctx,
   input  logic [kmse_pkg::TickWidth-1:0]  debounce_ticks,
   input  kmse_pkg::req_type               sense,
   output kmse_pkg::scan_ctx_type          ctx_next,
   output kmse_pkg::rsp_type               result
);

   // Returns {found, index of lowest low line}.
   function automatic logic [4:0] first_low(input logic [9:0] lines);
      logic [4:0] r;
      r = 5'd0;
      for (int i = 9; i >= 0; i--) begin
         if (!lines[i]) begin
            r = {1'b1, 4'(i)};
         end
      end
      return r;
   endfunction

   logic [4:0]                       col_g1;
   logic [4:0]                       col_g2;
   logic [4:0]                       row_g1;
   logic [4:0]                       row_g2;
   logic [kmse_pkg::ColIdxWidth-1:0] c1;
   logic [kmse_pkg::ColIdxWidth-1:0] c2;
   logic [kmse_pkg::ColIdxWidth-1:0] c2_off;
   logic                             caps_hit;
   logic                             caps_new;
   logic [kmse_pkg::CodeWidth-1:0]   code_g1;
   logic [kmse_pkg::CodeWidth-1:0]   code_g1_cased;
   logic [kmse_pkg::CodeWidth-1:0]   code_g2;

   assign col_g1 = first_low(sense.col_sense[9:0]);
   assign col_g2 = first_low({6'h3f, sense.col_sense[13:10]});
   assign row_g1 = first_low({7'h7f, sense.row_sense[2:0]});
   assign row_g2 = first_low({5'h1f, sense.row_sense[7:3]});

   assign c1 = (ctx.held_column > kmse_pkg::G1_LAST_COL) ? kmse_pkg::G1_LAST_COL
                                                          : ctx.held_column;
   assign c2 = (ctx.held_column < kmse_pkg::G2_FIRST_COL) ? kmse_pkg::G2_FIRST_COL :
               (ctx.held_column > kmse_pkg::G2_LAST_COL)  ? kmse_pkg::G2_LAST_COL
                                                          : ctx.held_column;
   assign c2_off = c2 - kmse_pkg::G2_FIRST_COL;

   assign caps_hit = (row_g1[3:0] == kmse_pkg::CAPS_ROW) && (c1 == kmse_pkg::CAPS_COL);
   assign caps_new = ctx.caps_flag ^ caps_hit;

   assign code_g1 = (row_g1[1:0] < 2'd3) ? kmse_pkg::MAP_G1[row_g1[1:0]][c1]
                                          : kmse_pkg::MAP_G1[2][c1];
   assign code_g1_cased = (caps_new && code_g1 > kmse_pkg::LOWER_FLOOR
                           && code_g1 < kmse_pkg::LOWER_CEIL)
                          ? code_g1 - kmse_pkg::CASE_OFFSET : code_g1;
   assign code_g2 = (row_g2[2:0] < 3'd5) ? kmse_pkg::MAP_G2[row_g2[2:0]][c2_off[1:0]]
                                          : kmse_pkg::MAP_G2[4][c2_off[1:0]];

   always_comb begin
      ctx_next           = ctx;
      result.drive_phase = kmse_pkg::PHASE_G1_COLS;
      result.key_valid   = 1'b0;
      result.key_code    = '0;
      result.key_held    = 1'b0;
      unique case (ctx.scan)
         kmse_pkg::G1_COL: begin
            if (col_g1[4]) begin
               ctx_next.held_column = col_g1[3:0];
               ctx_next.wait_count  = debounce_ticks;
               ctx_next.scan        = kmse_pkg::G1_WAIT;
            end else begin
               ctx_next.scan = kmse_pkg::G2_COL;
            end
         end
         kmse_pkg::G1_WAIT: begin
            if (ctx.wait_count != '0) begin
               ctx_next.wait_count = ctx.wait_count - 1'b1;
            end else begin
               ctx_next.scan = kmse_pkg::G1_ROW;
            end
         end
         kmse_pkg::G1_ROW: begin
            result.drive_phase = kmse_pkg::PHASE_G1_ROWS;
            if (row_g1[4]) begin
               result.key_valid   = 1'b1;
               result.key_code    = code_g1_cased;
               ctx_next.caps_flag = caps_new;
               ctx_next.scan      = kmse_pkg::G1_HOLD;
            end else begin
               ctx_next.scan = kmse_pkg::G2_COL;
            end
         end
         kmse_pkg::G1_HOLD: begin
            result.drive_phase = kmse_pkg::PHASE_G1_ROWS;
            result.key_held    = 1'b1;
            if (!row_g1[4]) begin
               ctx_next.scan = kmse_pkg::G2_COL;
            end
         end
         kmse_pkg::G2_COL: begin
            result.drive_phase = kmse_pkg::PHASE_G2_COLS;
            if (col_g2[4]) begin
               ctx_next.held_column = kmse_pkg::G2_FIRST_COL + col_g2[3:0];
               ctx_next.wait_count  = debounce_ticks;
               ctx_next.scan        = kmse_pkg::G2_WAIT;
            end else begin
               ctx_next.scan = kmse_pkg::G1_COL;
            end
         end
         kmse_pkg::G2_WAIT: begin
            result.drive_phase = kmse_pkg::PHASE_G2_COLS;
            if (ctx.wait_count != '0) begin
               ctx_next.wait_count = ctx.wait_count - 1'b1;
            end else begin
               ctx_next.scan = kmse_pkg::G2_ROW;
            end
         end
         kmse_pkg::G2_ROW: begin
            result.drive_phase = kmse_pkg::PHASE_G2_ROWS;
            if (row_g2[4]) begin
               result.key_valid = 1'b1;
               result.key_code  = code_g2;
               ctx_next.scan    = kmse_pkg::G2_HOLD;
            end else begin
               ctx_next.scan = kmse_pkg::G1_COL;
            end
         end
         kmse_pkg::G2_HOLD: begin
            result.drive_phase = kmse_pkg::PHASE_G2_ROWS;
            result.key_held    = 1'b1;
            if (!row_g2[4]) begin
               ctx_next.scan = kmse_pkg::G1_COL;
            end
         end
         default: begin
            ctx_next.scan = kmse_pkg::G1_COL;
         end
      endcase
      result.caps_on = ctx_next.caps_flag;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/key_matrix_scan_encoder.sv =====
// Path: an accepted request is held in the input register and then passes into the result
// register, where rsp_valid rises; a stalled response holds the request in the input register.
// Throughput: one request per cycle while responses are taken; the scan context updates
// as each request passes from the input register into the result register.
// Reset: synchronous; scan restarts at group one column sense, caps off,
// debounce_ticks = 50. No clearing pass.
`default_nettype none

module key_matrix_scan_encoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  kmse_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output kmse_pkg::rsp_type               rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [kmse_pkg::TickWidth-1:0]  csr_data
);

   logic                           in_valid_ff;
   kmse_pkg::req_type              in_data_ff;
   logic                           out_valid_ff;
   kmse_pkg::rsp_type              out_data_ff;
   kmse_pkg::scan_ctx_type         ctx_ff;
   kmse_pkg::scan_ctx_type         ctx_in;
   kmse_pkg::rsp_type              out_data_in;
   logic [kmse_pkg::TickWidth-1:0] debounce_ff;
   logic                           advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   kmse_step u_step (
      .ctx            (ctx_ff),
      .debounce_ticks (debounce_ff),
      .sense          (in_data_ff),
      .ctx_next       (ctx_in),
      .result         (out_data_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         debounce_ff  <= kmse_pkg::DEBOUNCE_RESET;
         ctx_ff       <= '{scan: kmse_pkg::G1_COL, wait_count: '0,
                           held_column: '0, caps_flag: 1'b0};
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            ctx_ff       <= ctx_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_valid) begin
            debounce_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

`default_nettype wire
